>>> rtl/gle_pkg.sv
// gle_pkg: shared types and constants of the greek letter expander
// used by gle_front, gle_queue, gle_back and greek_letter_expander
`default_nettype none

package gle_pkg;

   localparam logic [7:0] LEAD_CE = 8'hCE;
   localparam logic [7:0] LEAD_CF = 8'hCF;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int         QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      WORD_ALPHA,
      WORD_BETA,
      WORD_GAMMA,
      WORD_DELTA,
      WORD_KAPPA,
      WORD_LAMBDA,
      WORD_MU,
      WORD_TAU,
      WORD_NU
   } word_id_type;

   typedef enum logic [1:0] {
      CMD_ONE,
      CMD_TWO,
      CMD_WORD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      word_id_type  word;
      logic [7:0]   byte0;
      logic [7:0]   byte1;
      logic         last;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/greek_letter_expander.sv
// greek_letter_expander: top level joining front end, command queue and back end
// depends on gle_pkg, gle_front, gle_queue and gle_back
`default_nettype none

// Expands two-byte Greek letter codes in a UTF-8 byte stream into space-padded
// ASCII words. Plain bytes flow at one byte per cycle when neither side stalls;
// a lead byte 0xCE/0xCF that does not end its string is held inside and yields
// nothing until the following byte arrives. A matched pair produces 4 to 8
// output bytes, one per cycle from the single output register of the back end
// while the receiver does not stall. A four-entry command queue sits between
// input and output; input is stalled only while that queue is full. No clearing
// pass is needed after reset.

module greek_letter_expander (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_end,
   output logic            rsp_string_end
);

   logic             q_push;
   gle_pkg::cmd_type q_push_cmd;
   logic             q_pop;
   gle_pkg::cmd_type q_head_cmd;
   logic             q_head_valid;
   logic             q_full;
   logic             lead_held;

   gle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (q_full),
      .push        (q_push),
      .push_cmd    (q_push_cmd),
      .lead_held   (lead_held)
   );

   gle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_cmd   (q_head_cmd),
      .head_valid (q_head_valid),
      .full       (q_full)
   );

   gle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (q_head_cmd),
      .head_valid     (q_head_valid),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("command popped from empty queue");

   a_last_flushes : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_in_last) |=> !lead_held)
      else $error("lead byte still held after end of string");

   a_string_end_run_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_end)
      else $error("string end without run end");

endmodule

`default_nettype wire

>>> rtl/gle_front.sv
// gle_front: accepts input bytes, tracks a held lead byte and classifies
// each transaction into an emit command; depends on gle_pkg
`default_nettype none

module gle_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [7:0]      req_in_byte,
   input  wire logic            req_in_last,
   input  wire logic            queue_full,
   output logic                 push,
   output gle_pkg::cmd_type     push_cmd,
   output logic                 lead_held
);

   logic lead_held_ff, lead_held_in;
   logic lead_is_cf_ff, lead_is_cf_in;
   logic accept;
   logic is_lead;
   logic pair_hit;
   gle_pkg::word_id_type pair_word;
   logic [7:0] held_byte;

   always_comb begin
      pair_hit  = 1'b0;
      pair_word = gle_pkg::WORD_ALPHA;
      if (lead_is_cf_ff) begin
         if (req_in_byte == 8'h84) begin
            pair_hit  = 1'b1;
            pair_word = gle_pkg::WORD_TAU;
         end
      end else begin
         pair_hit = 1'b1;
         case (req_in_byte) inside
            8'hB1, 8'h91: pair_word = gle_pkg::WORD_ALPHA;
            8'hB2, 8'h92: pair_word = gle_pkg::WORD_BETA;
            8'hB3, 8'h93: pair_word = gle_pkg::WORD_GAMMA;
            8'hB4, 8'h94: pair_word = gle_pkg::WORD_DELTA;
            8'hBA, 8'h9A: pair_word = gle_pkg::WORD_KAPPA;
            8'hBB, 8'h9B: pair_word = gle_pkg::WORD_LAMBDA;
            8'hBC, 8'h9C: pair_word = gle_pkg::WORD_MU;
            8'hA4:        pair_word = gle_pkg::WORD_TAU;
            8'hBD, 8'h9D: pair_word = gle_pkg::WORD_NU;
            default:      pair_hit  = 1'b0;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_lead   = (req_in_byte == gle_pkg::LEAD_CE) || (req_in_byte == gle_pkg::LEAD_CF);
   assign held_byte = lead_is_cf_ff ? gle_pkg::LEAD_CF : gle_pkg::LEAD_CE;

   always_comb begin
      lead_held_in   = lead_held_ff;
      lead_is_cf_in  = lead_is_cf_ff;
      push           = 1'b0;
      push_cmd.kind  = gle_pkg::CMD_ONE;
      push_cmd.word  = pair_word;
      push_cmd.byte0 = req_in_byte;
      push_cmd.byte1 = req_in_byte;
      push_cmd.last  = req_in_last;
      if (accept) begin
         lead_held_in  = 1'b0;
         lead_is_cf_in = 1'b0;
         if (lead_held_ff && pair_hit) begin
            push          = 1'b1;
            push_cmd.kind = gle_pkg::CMD_WORD;
         end else if (lead_held_ff) begin
            push           = 1'b1;
            push_cmd.byte0 = held_byte;
            if (is_lead && !req_in_last) begin
               push_cmd.kind = gle_pkg::CMD_ONE;
               lead_held_in  = 1'b1;
               lead_is_cf_in = (req_in_byte == gle_pkg::LEAD_CF);
            end else begin
               push_cmd.kind = gle_pkg::CMD_TWO;
            end
         end else if (is_lead && !req_in_last) begin
            lead_held_in  = 1'b1;
            lead_is_cf_in = (req_in_byte == gle_pkg::LEAD_CF);
         end else begin
            push          = 1'b1;
            push_cmd.kind = gle_pkg::CMD_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_held_ff  <= 1'b0;
         lead_is_cf_ff <= 1'b0;
      end else begin
         lead_held_ff  <= lead_held_in;
         lead_is_cf_ff <= lead_is_cf_in;
      end
   end

   assign lead_held = lead_held_ff;

endmodule

`default_nettype wire

>>> rtl/gle_queue.sv
// gle_queue: small command fifo between front and back end
// depends on gle_pkg for the command type and depth
`default_nettype none

module gle_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gle_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output gle_pkg::cmd_type      head_cmd,
   output logic                  head_valid,
   output logic                  full
);

   gle_pkg::cmd_type entry_ff [gle_pkg::QUEUE_DEPTH];
   logic [gle_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gle_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gle_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = (count_ff == gle_pkg::QUEUE_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/gle_back.sv
// gle_back: walks the head command one output byte per cycle into the registered
// result port while it is not stalled; depends on gle_pkg
`default_nettype none

module gle_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire gle_pkg::cmd_type head_cmd,
   input  wire logic             head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_end,
   output logic                  rsp_string_end
);

   function automatic logic [63:0] word_text(gle_pkg::word_id_type id);
      logic [63:0] t;
      case (id)
         gle_pkg::WORD_ALPHA:  t = " alpha ";
         gle_pkg::WORD_BETA:   t = " beta ";
         gle_pkg::WORD_GAMMA:  t = " gamma ";
         gle_pkg::WORD_DELTA:  t = " delta ";
         gle_pkg::WORD_KAPPA:  t = " kappa ";
         gle_pkg::WORD_LAMBDA: t = " lambda ";
         gle_pkg::WORD_MU:     t = " mu ";
         gle_pkg::WORD_TAU:    t = " tau ";
         gle_pkg::WORD_NU:     t = " nu ";
         default:              t = '0;
      endcase
      return t;
   endfunction

   // word length minus one
   function automatic logic [2:0] word_last(gle_pkg::word_id_type id);
      logic [2:0] n;
      case (id)
         gle_pkg::WORD_ALPHA:  n = 3'd6;
         gle_pkg::WORD_BETA:   n = 3'd5;
         gle_pkg::WORD_GAMMA:  n = 3'd6;
         gle_pkg::WORD_DELTA:  n = 3'd6;
         gle_pkg::WORD_KAPPA:  n = 3'd6;
         gle_pkg::WORD_LAMBDA: n = 3'd7;
         gle_pkg::WORD_MU:     n = 3'd3;
         gle_pkg::WORD_TAU:    n = 3'd4;
         gle_pkg::WORD_NU:     n = 3'd3;
         default:              n = 3'd0;
      endcase
      return n;
   endfunction

   logic [2:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        run_end_ff, run_end_in;
   logic        string_end_ff, string_end_in;
   logic        load;
   logic [2:0]  last_pos;
   logic [2:0]  shift;
   logic [63:0] text;
   logic        at_end;

   assign load  = !valid_ff || !rsp_stall;
   assign text  = word_text(head_cmd.word);
   assign shift = last_pos - pos_ff;

   always_comb begin
      case (head_cmd.kind)
         gle_pkg::CMD_ONE: begin
            last_pos = 3'd0;
            byte_in  = head_cmd.byte0;
         end
         gle_pkg::CMD_TWO: begin
            last_pos = 3'd1;
            byte_in  = (pos_ff == 3'd0) ? head_cmd.byte0 : head_cmd.byte1;
         end
         gle_pkg::CMD_WORD: begin
            last_pos = word_last(head_cmd.word);
            byte_in  = 8'(text >> {shift, 3'b000});
         end
         default: begin
            last_pos = 3'd0;
            byte_in  = head_cmd.byte0;
         end
      endcase
   end

   assign at_end        = (pos_ff == last_pos);
   assign run_end_in    = at_end;
   assign string_end_in = at_end && head_cmd.last;
   assign pop           = head_valid && load && at_end;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            pos_in = at_end ? 3'd0 : pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         byte_ff       <= byte_in;
         run_end_ff    <= run_end_in;
         string_end_ff <= string_end_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_string_end = string_end_ff;

endmodule

`default_nettype wire

>>> tb/tb_greek_letter_expander.sv
// tb_greek_letter_expander: self-checking testbench for greek_letter_expander
// drives directed and random UTF-8 strings, predicts the expanded text and checks it
// depends on gle_pkg and the greek_letter_expander rtl
`timescale 1ns / 1ps

module tb_greek_letter_expander;

   localparam int NUM_RANDOM_ITEMS = 410;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_START = 300;
   localparam int HOLD_CYCLES = 120;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
   } expanded_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   wire logic  req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   wire logic  rsp_valid;
   logic       rsp_stall = 1'b0;
   wire logic [7:0] rsp_out_byte;
   wire logic  rsp_run_end;
   wire logic  rsp_string_end;

   text_byte_type     source_text[$];
   expanded_byte_type expanded_text_q[$];
   text_byte_type     next_in;
   expanded_byte_type want;

   logic lead_held = 1'b0;
   logic lead_is_cf = 1'b0;
   int   error_count = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_cycle = 0;
   int   hold_left = 0;
   int   phase_left = 0;
   int   stall_pct = 0;

   greek_letter_expander u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic match_greek(input logic cf, input logic [7:0] b,
                                        output gle_pkg::word_id_type w);
      w = gle_pkg::WORD_ALPHA;
      if (cf) begin
         w = gle_pkg::WORD_TAU;
         return b == 8'h84;
      end
      case (b)
         8'hB1, 8'h91: w = gle_pkg::WORD_ALPHA;
         8'hB2, 8'h92: w = gle_pkg::WORD_BETA;
         8'hB3, 8'h93: w = gle_pkg::WORD_GAMMA;
         8'hB4, 8'h94: w = gle_pkg::WORD_DELTA;
         8'hBA, 8'h9A: w = gle_pkg::WORD_KAPPA;
         8'hBB, 8'h9B: w = gle_pkg::WORD_LAMBDA;
         8'hBC, 8'h9C: w = gle_pkg::WORD_MU;
         8'hA4:        w = gle_pkg::WORD_TAU;
         8'hBD, 8'h9D: w = gle_pkg::WORD_NU;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic string word_text(input gle_pkg::word_id_type w);
      case (w)
         gle_pkg::WORD_ALPHA:  return " alpha ";
         gle_pkg::WORD_BETA:   return " beta ";
         gle_pkg::WORD_GAMMA:  return " gamma ";
         gle_pkg::WORD_DELTA:  return " delta ";
         gle_pkg::WORD_KAPPA:  return " kappa ";
         gle_pkg::WORD_LAMBDA: return " lambda ";
         gle_pkg::WORD_MU:     return " mu ";
         gle_pkg::WORD_TAU:    return " tau ";
         default:              return " nu ";
      endcase
   endfunction

   // lead and second byte of one of the eighteen recognized codes
   function automatic logic [15:0] greek_code(input int idx);
      logic [7:0] seconds [17];
      seconds = '{8'hB1, 8'h91, 8'hB2, 8'h92, 8'hB3, 8'h93, 8'hB4, 8'h94, 8'hBA,
                  8'h9A, 8'hBB, 8'h9B, 8'hBC, 8'h9C, 8'hA4, 8'hBD, 8'h9D};
      if (idx >= 17)
         return {gle_pkg::LEAD_CF, 8'h84};
      return {gle_pkg::LEAD_CE, seconds[idx]};
   endfunction

   task automatic expand_byte(input logic [7:0] b, input logic last);
      logic [7:0]           outs[$];
      gle_pkg::word_id_type w;
      string                txt;
      logic                 fresh;
      expanded_byte_type    e;
      int                   i;
      fresh = 1'b1;
      if (lead_held) begin
         lead_held = 1'b0;
         if (match_greek(lead_is_cf, b, w)) begin
            txt = word_text(w);
            for (i = 0; i < txt.len(); i++)
               outs.insert(outs.size(), txt[i]);
            fresh = 1'b0;
         end else begin
            outs.insert(outs.size(), lead_is_cf ? gle_pkg::LEAD_CF : gle_pkg::LEAD_CE);
         end
         lead_is_cf = 1'b0;
      end
      if (fresh) begin
         if ((b == gle_pkg::LEAD_CE || b == gle_pkg::LEAD_CF) && !last) begin
            lead_held = 1'b1;
            lead_is_cf = (b == gle_pkg::LEAD_CF);
         end else begin
            outs.insert(outs.size(), b);
         end
      end
      for (i = 0; i < outs.size(); i++) begin
         e.data = outs[i];
         e.run_end = (i == outs.size() - 1);
         e.string_end = last && (i == outs.size() - 1);
         expanded_text_q.insert(expanded_text_q.size(), e);
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic last);
      text_byte_type t;
      t.data = b;
      t.last = last;
      source_text.insert(source_text.size(), t);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expand_byte(req_in_byte, req_in_last);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (source_text.size() > 0) begin
               next_in = source_text.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= next_in.data;
               req_in_last <= next_in.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycle++;
         if (stall_cycle == HOLD_START)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(5, 40);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            phase_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expanded_text_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, byte %02h",
                                         rsp_out_byte));
            end else begin
               want = expanded_text_q.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.data));
               if (rsp_run_end !== want.run_end)
                  report_mismatch($sformatf("run_end %b, expected %b",
                                            rsp_run_end, want.run_end));
               if (rsp_string_end !== want.string_end)
                  report_mismatch($sformatf("string_end %b, expected %b",
                                            rsp_string_end, want.string_end));
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_greek_letter_expander: errors");
            $finish;
         end
      end
   end

   initial begin
      int       n;
      int       len;
      int       k;
      int       kind;
      logic     fin;
      logic [15:0] code;

      // matched codes, upper and lower case, then plain extremes
      add_byte(gle_pkg::LEAD_CE, 1'b0); add_byte(8'hB1, 1'b0);
      add_byte(gle_pkg::LEAD_CF, 1'b0); add_byte(8'h84, 1'b0);
      add_byte(gle_pkg::LEAD_CE, 1'b0); add_byte(8'hA4, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      // mismatched pairs and a lead that follows a held lead
      add_byte(gle_pkg::LEAD_CE, 1'b0); add_byte(8'h41, 1'b0);
      add_byte(gle_pkg::LEAD_CE, 1'b0); add_byte(gle_pkg::LEAD_CE, 1'b0);
      add_byte(8'h9D, 1'b0);
      add_byte(gle_pkg::LEAD_CF, 1'b0); add_byte(8'hB1, 1'b0);
      // lead on the last byte is flushed
      add_byte(gle_pkg::LEAD_CE, 1'b1);
      add_byte(gle_pkg::LEAD_CF, 1'b0); add_byte(gle_pkg::LEAD_CF, 1'b1);
      add_byte(gle_pkg::LEAD_CE, 1'b0); add_byte(8'h9B, 1'b1);
      add_byte(8'h7F, 1'b1);

      n = source_text.size();
      while (source_text.size() < n + NUM_RANDOM_ITEMS) begin
         len = $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            fin = (k == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
               code = greek_code($urandom_range(0, 17));
               add_byte(code[15:8], 1'b0);
               add_byte(code[7:0], fin);
            end else if (kind < 68) begin
               // broken pair: lead then arbitrary byte
               add_byte($urandom_range(0, 1) ? gle_pkg::LEAD_CF : gle_pkg::LEAD_CE, 1'b0);
               add_byte(8'($urandom_range(0, 255)), fin);
            end else if (kind < 74) begin
               add_byte($urandom_range(0, 1) ? gle_pkg::LEAD_CF : gle_pkg::LEAD_CE, fin);
            end else begin
               add_byte(8'($urandom_range(0, 255)), fin);
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (source_text.size() > 0 || req_valid || expanded_text_q.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (expanded_text_q.size() > 0)
         report_mismatch($sformatf("%0d expected bytes never arrived",
                                   expanded_text_q.size()));
      if (error_count == 0)
         $display("tb_greek_letter_expander: clean");
      else
         $display("tb_greek_letter_expander: errors");
      $finish;
   end

endmodule
